// ===== rtl/urlenc_pkg.sv =====
// Package with the shared types, constants and character class functions of the URL encoder.
`default_nettype none
package urlenc_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;
    localparam int STATUS_W    = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_PART_SELECT   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE_AST    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPACE_PLUS    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPACE_PERCENT = 8'd3;

    localparam logic [2:0] PART_HOST     = 3'd0;
    localparam logic [2:0] PART_PATH     = 3'd1;
    localparam logic [2:0] PART_SEGMENT  = 3'd2;
    localparam logic [2:0] PART_QKEY     = 3'd3;
    localparam logic [2:0] PART_QVALUE   = 3'd4;
    localparam logic [2:0] PART_FRAGMENT = 3'd5;
    localparam logic [2:0] PART_USERINFO = 3'd6;
    localparam logic [2:0] PART_FORM     = 3'd7;

    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_STAR    = 8'h2A;
    localparam logic [3:0] NIBBLE_MASK  = 4'hF;

    typedef struct packed {
        logic [2:0] part_select;
        logic       escape_asterisk;
        logic       force_space_plus;
        logic       force_space_percent;
    } cfg_t;

    // What one accepted byte produces: up to three data results and an optional status.
    typedef struct packed {
        logic [1:0]          data_n;
        logic                escape;
        logic [7:0]          src_char;
        logic [7:0]          emit_char;
        logic                has_status;
        logic [STATUS_W-1:0] count;
        logic                fits;
    } plan_t;

    function automatic logic is_unres(input logic [7:0] c);
        is_unres = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
                   (c >= "0" && c <= "9") || c == "-" || c == "." ||
                   c == "_" || c == "~";
    endfunction

    function automatic logic is_sub(input logic [7:0] c);
        is_sub = c == "!" || c == "$" || c == "&" || c == 8'h27 || c == "(" ||
                 c == ")" || c == "*" || c == "+" || c == "," || c == ";" ||
                 c == "=";
    endfunction

    function automatic logic is_path_char(input logic [7:0] c);
        is_path_char = is_unres(c) || is_sub(c) || c == ":" || c == "@";
    endfunction

    function automatic logic passes_in_part(input logic [7:0] c, input logic [2:0] sel);
        logic amp_eq;
        amp_eq = (c == "&") || (c == "=");
        case (sel)
            PART_HOST:     passes_in_part = is_unres(c) || is_sub(c) || c == "[" ||
                                            c == "]" || c == ":";
            PART_PATH:     passes_in_part = (c == "/") || (!amp_eq && is_path_char(c));
            PART_SEGMENT:  passes_in_part = !amp_eq && is_path_char(c);
            PART_QKEY:     passes_in_part = !amp_eq && c != "/" && c != "?" &&
                                            is_path_char(c);
            PART_QVALUE:   passes_in_part = !amp_eq &&
                                            (is_path_char(c) || c == "/" || c == "?");
            PART_FRAGMENT: passes_in_part = is_path_char(c) || c == "/" || c == "?";
            PART_USERINFO: passes_in_part = is_unres(c) || is_sub(c);
            default:       passes_in_part = is_unres(c);
        endcase
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        if (n < 4'd10)
        begin
            hex_digit = 8'h30 + {4'd0, n};
        end
        else
        begin
            hex_digit = 8'h37 + {4'd0, n};
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/urlenc_in_if.sv =====
// Interface for the input byte channel of the URL encoder.
`default_nettype none
interface urlenc_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        first_of_string;
    logic        last_of_string;
    logic [15:0] out_capacity;
    logic [15:0] source_length;

    modport source (output valid, data_byte, first_of_string, last_of_string,
                    out_capacity, source_length, input ready);
    modport sink (input valid, data_byte, first_of_string, last_of_string,
                  out_capacity, source_length, output ready);
endinterface
`default_nettype wire

// ===== rtl/urlenc_out_if.sv =====
// Interface for the result channel of the URL encoder.
`default_nettype none
interface urlenc_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_char;
    logic        is_status;
    logic [15:0] written_count;
    logic        fits;
    logic        end_of_run;

    modport source (output valid, out_char, is_status, written_count, fits, end_of_run,
                    input ready);
    modport sink (input valid, out_char, is_status, written_count, fits, end_of_run,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/urlenc_cfg_if.sv =====
// Interface for the configuration write channel of the URL encoder.
`default_nettype none
interface urlenc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/url_percent_encoder_unit.sv =====
// Top level of the URL percent encoder: configuration, string state and result sequencing.
// The first result of an item passes through the plan register and then the output register.
// Throughput: one result per cycle while the output is ready; the next item waits at the input
// until the last of an item's results (one to four) moves out, set by the single result port.
// Reset clears the string state and returns the registers to form part, no asterisk escape
// and the default space rule.
`default_nettype none
module url_percent_encoder_unit #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    urlenc_in_if.sink     in_ch,
    urlenc_out_if.source  out_ch,
    urlenc_cfg_if.sink    cfg_ch
);
    import urlenc_pkg::*;

    localparam int CW = COUNT_BITS;
    localparam logic [32:0] CNT_MAX = (33'd1 << CW) - 33'd1;

    cfg_t          cfg_reg;
    logic [CW-1:0] wp_reg;
    logic [CW-1:0] cap_reg;
    logic          ovf_reg;
    logic [CW-1:0] wp_next;
    logic          ovf_next;

    logic          accept;
    logic          can_load;
    logic          escape;
    logic [7:0]    emit_char;
    logic [32:0]   cap_wide;
    logic [CW-1:0] cap_sat;
    logic [CW-1:0] wp_eff;
    logic [CW-1:0] cap_eff;
    logic          ovf_eff;
    logic          fit1;
    logic          fit3;
    logic [1:0]    data_n;
    logic [32:0]   wp_wide;
    plan_t         plan;
    logic          load;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = can_load;
    assign accept       = in_ch.valid && can_load;

    urlenc_encode u_encode (
        .data_byte (in_ch.data_byte),
        .cfg       (cfg_reg),
        .escape    (escape),
        .emit_char (emit_char)
    );

    always_comb
    begin
        cap_wide = {17'd0, in_ch.out_capacity};
        cap_sat  = (cap_wide > CNT_MAX) ? CNT_MAX[CW-1:0] : cap_wide[CW-1:0];
        if (in_ch.first_of_string)
        begin
            wp_eff  = '0;
            cap_eff = cap_sat;
            ovf_eff = in_ch.out_capacity < in_ch.source_length;
        end
        else
        begin
            wp_eff  = wp_reg;
            cap_eff = cap_reg;
            ovf_eff = ovf_reg;
        end

        fit1 = {2'b0, cap_eff} > {2'b0, wp_eff};
        fit3 = {2'b0, cap_eff} >= ({2'b0, wp_eff} + (CW+2)'(3));

        data_n   = 2'd0;
        ovf_next = ovf_eff;
        if (!ovf_eff)
        begin
            if (escape)
            begin
                if (fit3)
                begin
                    data_n = 2'd3;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            else if (fit1)
            begin
                data_n = 2'd1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        wp_next = wp_eff + CW'(data_n);
        wp_wide = 33'(wp_next);

        plan.data_n     = data_n;
        plan.escape     = escape;
        plan.src_char   = in_ch.data_byte;
        plan.emit_char  = emit_char;
        plan.has_status = in_ch.last_of_string;
        plan.count      = wp_wide[STATUS_W-1:0];
        plan.fits       = !ovf_next;

        load = accept && ((data_n != 2'd0) || in_ch.last_of_string);
    end

    urlenc_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .plan     (plan),
        .can_load (can_load),
        .out_ch   (out_ch)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.part_select         <= PART_FORM;
            cfg_reg.escape_asterisk     <= 1'b0;
            cfg_reg.force_space_plus    <= 1'b0;
            cfg_reg.force_space_percent <= 1'b0;
            wp_reg  <= '0;
            cap_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                case (cfg_ch.index)
                    REG_PART_SELECT:   cfg_reg.part_select         <= cfg_ch.data[2:0];
                    REG_ESCAPE_AST:    cfg_reg.escape_asterisk     <= cfg_ch.data[0];
                    REG_SPACE_PLUS:    cfg_reg.force_space_plus    <= cfg_ch.data[0];
                    REG_SPACE_PERCENT: cfg_reg.force_space_percent <= cfg_ch.data[0];
                    default:           ;
                endcase
            end
            if (accept)
            begin
                wp_reg  <= wp_next;
                cap_reg <= cap_eff;
                ovf_reg <= ovf_next;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/urlenc_encode.sv =====
// Character classifier that decides whether a byte is escaped and what plain byte it becomes.
`default_nettype none
module urlenc_encode (
    input  wire logic [7:0]       data_byte,
    input  wire urlenc_pkg::cfg_t cfg,
    output logic                  escape,
    output logic [7:0]            emit_char
);
    import urlenc_pkg::*;

    logic plus_space;

    always_comb
    begin
        if (cfg.force_space_plus)
        begin
            plus_space = 1'b1;
        end
        else if (cfg.force_space_percent)
        begin
            plus_space = 1'b0;
        end
        else
        begin
            plus_space = (cfg.part_select == PART_FORM);
        end

        emit_char = data_byte;
        if (data_byte == CHAR_SPACE)
        begin
            escape = !plus_space;
            if (plus_space)
            begin
                emit_char = CHAR_PLUS;
            end
        end
        else if (data_byte == CHAR_STAR)
        begin
            escape = cfg.escape_asterisk;
        end
        else
        begin
            escape = !passes_in_part(data_byte, cfg.part_select);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/urlenc_emit.sv =====
// Result sequencer that holds one item's plan and feeds its results into the output register.
`default_nettype none
module urlenc_emit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire urlenc_pkg::plan_t plan,
    output logic                   can_load,
    urlenc_out_if.source           out_ch
);
    import urlenc_pkg::*;

    logic          pend_valid_reg;
    logic          pend_valid_next;
    plan_t         plan_reg;
    logic [1:0]    idx_reg;
    logic [1:0]    idx_next;
    logic          out_valid_reg;
    logic [7:0]    out_char_reg;
    logic          is_status_reg;
    logic [15:0]   count_reg;
    logic          fits_reg;
    logic          eor_reg;

    logic [2:0]    total;
    logic          move;
    logic          is_last;
    logic [7:0]    cur_char;
    logic          cur_status;

    assign total   = {1'b0, plan_reg.data_n} + {2'b0, plan_reg.has_status};
    assign move    = pend_valid_reg && (!out_valid_reg || out_ch.ready);
    assign is_last = ({1'b0, idx_reg} == (total - 3'd1));
    assign can_load = !pend_valid_reg || (move && is_last);

    always_comb
    begin
        cur_status = ({1'b0, idx_reg} >= {1'b0, plan_reg.data_n});
        if (!plan_reg.escape)
        begin
            cur_char = plan_reg.emit_char;
        end
        else
        begin
            case (idx_reg)
                2'd0:    cur_char = CHAR_PERCENT;
                2'd1:    cur_char = hex_digit(plan_reg.src_char[7:4]);
                2'd2:    cur_char = hex_digit(plan_reg.src_char[3:0] & NIBBLE_MASK);
                default: cur_char = 8'd0;
            endcase
        end
        if (cur_status)
        begin
            cur_char = 8'd0;
        end
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        idx_next        = idx_reg;
        if (move)
        begin
            if (is_last)
            begin
                pend_valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
        if (load)
        begin
            pend_valid_next = 1'b1;
            idx_next        = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            idx_reg        <= 2'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            idx_reg        <= idx_next;
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            plan_reg <= plan;
        end
        if (move)
        begin
            out_char_reg  <= cur_char;
            is_status_reg <= cur_status;
            count_reg     <= cur_status ? plan_reg.count : 16'd0;
            fits_reg      <= cur_status && plan_reg.fits;
            eor_reg       <= is_last;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.out_char      = out_char_reg;
    assign out_ch.is_status     = is_status_reg;
    assign out_ch.written_count = count_reg;
    assign out_ch.fits          = fits_reg;
    assign out_ch.end_of_run    = eor_reg;
endmodule
`default_nettype wire

// ===== tb/sv/tb_url_percent_encoder_unit.sv =====
// Self-checking testbench for the URL percent encoder: directed cases, then random strings.
`timescale 1ns / 100ps
`default_nettype none
module tb_url_percent_encoder_unit;
    import urlenc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEMS_PER_SETTING = 27;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LOW = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_TOP = 8'hFF;

    typedef struct packed {
        logic [7:0]  ch;
        logic        st;
        logic [15:0] cnt;
        logic        ok;
        logic        eor;
    } enc_result_t;

    logic clk = 1'b0;
    logic rst_n;

    urlenc_in_if  in_bus ();
    urlenc_out_if out_bus ();
    urlenc_cfg_if cfg_bus ();

    url_percent_encoder_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_bus),
        .out_ch (out_bus),
        .cfg_ch (cfg_bus)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    string hex_table = "0123456789ABCDEF";
    string url_punct = "!\"#$%&'()*+,-./:;<=>?@[]^_{|}~";

    // Shadow copy of the registers and the string state.
    logic [2:0]  cfg_part;
    logic        cfg_ast;
    logic        cfg_plus;
    logic        cfg_pct;
    logic [15:0] str_pos;
    logic [15:0] str_cap;
    logic        str_over;

    enc_result_t encoded_q [$];
    enc_result_t got_expected;

    int src_idle_pct;
    int snk_idle_pct;
    int mismatch_count;
    int cycle_count;
    int items_sent;

    function automatic logic is_plain(input logic [7:0] c);
        is_plain = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
                   (c >= "0" && c <= "9") || c == "-" || c == "." || c == "_" || c == "~";
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        is_delim = c == "!" || c == "$" || c == "&" || c == 8'h27 || c == "(" || c == ")" ||
                   c == "*" || c == "+" || c == "," || c == ";" || c == "=";
    endfunction

    function automatic logic char_passes(input logic [7:0] c, input logic [2:0] sel);
        logic pc;
        logic amp_eq;
        pc = is_plain(c) || is_delim(c) || c == ":" || c == "@";
        amp_eq = (c == "&") || (c == "=");
        case (sel)
            PART_HOST:     char_passes = is_plain(c) || is_delim(c) || c == "[" ||
                                         c == "]" || c == ":";
            PART_PATH:     char_passes = (c == "/") || (pc && !amp_eq);
            PART_SEGMENT:  char_passes = pc && !amp_eq;
            PART_QKEY:     char_passes = pc && !amp_eq && c != "/" && c != "?";
            PART_QVALUE:   char_passes = (pc || c == "/" || c == "?") && !amp_eq;
            PART_FRAGMENT: char_passes = pc || c == "/" || c == "?";
            PART_USERINFO: char_passes = is_plain(c) || is_delim(c);
            default:       char_passes = is_plain(c);
        endcase
    endfunction

    function automatic enc_result_t make_result(input logic [7:0] ch, input logic st,
                                                input logic [15:0] cnt, input logic ok);
        enc_result_t r;
        r.ch = ch;
        r.st = st;
        r.cnt = cnt;
        r.ok = ok;
        r.eor = 1'b0;
        return r;
    endfunction

    // Works out what one accepted byte produces and queues it.
    function automatic void encode_byte(input logic [7:0] c, input logic f, input logic l,
                                        input logic [15:0] cap, input logic [15:0] len);
        enc_result_t outs [0:3];
        int n;
        logic [15:0] room;
        logic plus_sp;
        logic esc;
        logic [7:0] emit;
        n = 0;
        if (f)
        begin
            str_pos = 16'd0;
            str_cap = cap;
            str_over = (cap < len);
        end
        if (!str_over)
        begin
            room = (str_cap > str_pos) ? str_cap - str_pos : 16'd0;
            if (cfg_plus)
                plus_sp = 1'b1;
            else if (cfg_pct)
                plus_sp = 1'b0;
            else
                plus_sp = (cfg_part == PART_FORM);
            emit = c;
            if (c == CHAR_SPACE)
            begin
                esc = !plus_sp;
                if (plus_sp)
                    emit = CHAR_PLUS;
            end
            else if (c == CHAR_STAR)
                esc = cfg_ast;
            else
                esc = !char_passes(c, cfg_part);
            if (esc)
            begin
                if (room < 16'd3)
                    str_over = 1'b1;
                else
                begin
                    outs[0] = make_result(CHAR_PERCENT, 1'b0, 16'd0, 1'b0);
                    outs[1] = make_result(hex_table[c[7:4]], 1'b0, 16'd0, 1'b0);
                    outs[2] = make_result(hex_table[c[3:0] & NIBBLE_MASK], 1'b0, 16'd0, 1'b0);
                    n = 3;
                    str_pos = str_pos + 16'd3;
                end
            end
            else if (room == 16'd0)
                str_over = 1'b1;
            else
            begin
                outs[0] = make_result(emit, 1'b0, 16'd0, 1'b0);
                n = 1;
                str_pos = str_pos + 16'd1;
            end
        end
        if (l)
        begin
            outs[n] = make_result(8'd0, 1'b1, str_pos, !str_over);
            n++;
        end
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
                outs[i].eor = 1'b1;
            encoded_q.push_back(outs[i]);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic f, input logic l,
                             input logic [15:0] cap, input logic [15:0] len);
        @(negedge clk);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_bus.valid <= 1'b0;
            @(negedge clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.data_byte <= b;
        in_bus.first_of_string <= f;
        in_bus.last_of_string <= l;
        in_bus.out_capacity <= cap;
        in_bus.source_length <= len;
        @(posedge clk);
        while (!in_bus.ready)
            @(posedge clk);
        encode_byte(b, f, l, cap, len);
        items_sent++;
    endtask

    // Holds the input off until every expected result is back and the block has settled.
    task automatic wait_idle();
        @(negedge clk);
        in_bus.valid <= 1'b0;
        while (encoded_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= val;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        case (idx)
            REG_PART_SELECT:   cfg_part = val[2:0];
            REG_ESCAPE_AST:    cfg_ast = val[0];
            REG_SPACE_PLUS:    cfg_plus = val[0];
            REG_SPACE_PERCENT: cfg_pct = val[0];
            default:           ;
        endcase
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        int k;
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            k = $urandom_range(0, 61);
            if (k < 26)
                pick_char = 8'("A" + k);
            else if (k < 52)
                pick_char = 8'("a" + (k - 26));
            else
                pick_char = 8'("0" + (k - 52));
        end
        else if (r < 60)
            pick_char = url_punct[$urandom_range(0, url_punct.len() - 1)];
        else if (r < 70)
            pick_char = CHAR_SPACE;
        else if (r < 75)
            pick_char = CHAR_STAR;
        else
            pick_char = 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random_string();
        int len;
        int mode;
        logic [15:0] cap;
        logic [15:0] slen;
        logic [15:0] junk_cap;
        logic [15:0] junk_len;
        logic drop_first;
        logic drop_last;
        logic f;
        logic l;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        slen = 16'(len);
        mode = $urandom_range(0, 9);
        case (mode)
            0, 1, 2, 3: cap = 16'(3 * len + $urandom_range(0, 2));
            4, 5:       cap = 16'($urandom_range(len, 2 * len));
            6:          cap = 16'($urandom_range(0, len - 1));
            7:
            begin
                cap = 16'($urandom);
                slen = 16'($urandom_range(1, 65535));
            end
            8:          cap = 16'hFFFF;
            default:    cap = 16'(3 * len - $urandom_range(1, 2));
        endcase
        drop_first = ($urandom_range(0, 19) == 0);
        drop_last = ($urandom_range(0, 19) == 0);
        for (int i = 0; i < len; i++)
        begin
            f = (i == 0) && !drop_first;
            l = (i == len - 1) && !drop_last;
            junk_cap = 16'($urandom);
            junk_len = 16'($urandom);
            send_byte(pick_char(), f, l, f ? cap : junk_cap, f ? slen : junk_len);
        end
    endtask

    task automatic send_stray_byte();
        logic [15:0] cap;
        logic [15:0] len;
        cap = 16'($urandom);
        len = 16'($urandom_range(1, 65535));
        send_byte(pick_char(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), cap, len);
    endtask

    task automatic test_after_reset();
        // The capacity is still zero, so a byte without the first mark overflows.
        send_byte("A", 1'b0, 1'b1, 16'd0, 16'd1);
        send_byte("a", 1'b1, 1'b0, 16'd8, 16'd4);
        send_byte(CHAR_SPACE, 1'b0, 1'b0, 16'd0, 16'd0);
        send_byte(CHAR_STAR, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF);
        send_byte("b", 1'b0, 1'b1, 16'd0, 16'd0);
    endtask

    task automatic test_special_cases();
        send_byte(8'h00, 1'b1, 1'b1, 16'd3, 16'd1);
        send_byte(8'hFF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
        // Rejection: capacity below the source length.
        send_byte("x", 1'b1, 1'b0, 16'd1, 16'd2);
        send_byte("y", 1'b0, 1'b1, 16'd0, 16'd0);
        // Overflow: the escape needs three bytes but only two are free.
        send_byte(CHAR_PERCENT, 1'b1, 1'b0, 16'd2, 16'd2);
        send_byte("a", 1'b0, 1'b1, 16'd0, 16'd0);
        // Bytes after the last mark continue on the held state.
        send_byte("a", 1'b1, 1'b0, 16'hFFFF, 16'd2);
        send_byte("b", 1'b0, 1'b1, 16'd0, 16'd0);
        send_byte("q", 1'b0, 1'b0, 16'd0, 16'd0);
        send_byte("r", 1'b0, 1'b1, 16'd0, 16'd0);
    endtask

    task automatic test_config_regs();
        wait_idle();
        write_reg(REG_ESCAPE_AST, 8'hFF);
        send_byte(CHAR_STAR, 1'b1, 1'b1, 16'd3, 16'd1);
        wait_idle();
        write_reg(REG_PART_SELECT, 8'hF8);
        write_reg(REG_SPACE_PLUS, 8'h01);
        send_byte(CHAR_SPACE, 1'b1, 1'b1, 16'd3, 16'd1);
        wait_idle();
        write_reg(REG_SPACE_PLUS, 8'hFE);
        write_reg(REG_SPACE_PERCENT, 8'hFF);
        write_reg(REG_PART_SELECT, 8'hFF);
        send_byte(CHAR_SPACE, 1'b1, 1'b1, 16'd3, 16'd1);
        wait_idle();
        write_reg(REG_SPACE_PLUS, 8'h01);
        write_reg(REG_UNUSED_LOW, 8'h00);
        write_reg(REG_UNUSED_TOP, 8'hFF);
        send_byte(CHAR_SPACE, 1'b1, 1'b0, 16'd4, 16'd2);
        send_byte(CHAR_STAR, 1'b0, 1'b1, 16'd0, 16'd0);
        wait_idle();
        write_reg(REG_PART_SELECT, {5'd0, PART_FORM});
        write_reg(REG_ESCAPE_AST, 8'h00);
        write_reg(REG_SPACE_PLUS, 8'h00);
        write_reg(REG_SPACE_PERCENT, 8'h00);
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct);
        int goal;
        logic [2:0] part;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int k = 0; k < 4; k++)
        begin
            wait_idle();
            if (k == 0)
                part = PART_HOST;
            else if (k == 3)
                part = PART_FORM;
            else
                part = 3'($urandom_range(0, 7));
            write_reg(REG_PART_SELECT, {5'($urandom_range(0, 31)), part});
            write_reg(REG_ESCAPE_AST, 8'($urandom_range(0, 255)));
            write_reg(REG_SPACE_PLUS, ($urandom_range(0, 2) == 0) ? 8'd1 : 8'd0);
            write_reg(REG_SPACE_PERCENT, 8'($urandom_range(0, 1)));
            goal = items_sent + ITEMS_PER_SETTING;
            while (items_sent < goal)
            begin
                if ($urandom_range(0, 99) < 85)
                    send_random_string();
                else
                    send_stray_byte();
            end
        end
    endtask

    always @(negedge clk)
    begin
        out_bus.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            if (encoded_q.size() == 0)
                report_mismatch("result item with none expected");
            else
            begin
                got_expected = encoded_q.pop_front();
                if (out_bus.out_char !== got_expected.ch)
                    report_mismatch($sformatf("out_char %h, expected %h",
                                              out_bus.out_char, got_expected.ch));
                if (out_bus.is_status !== got_expected.st)
                    report_mismatch($sformatf("is_status %b, expected %b",
                                              out_bus.is_status, got_expected.st));
                if (out_bus.written_count !== got_expected.cnt)
                    report_mismatch($sformatf("written_count %0d, expected %0d",
                                              out_bus.written_count, got_expected.cnt));
                if (out_bus.fits !== got_expected.ok)
                    report_mismatch($sformatf("fits %b, expected %b",
                                              out_bus.fits, got_expected.ok));
                if (out_bus.end_of_run !== got_expected.eor)
                    report_mismatch($sformatf("end_of_run %b, expected %b",
                                              out_bus.end_of_run, got_expected.eor));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_bus.valid = 1'b0;
        in_bus.data_byte = 8'd0;
        in_bus.first_of_string = 1'b0;
        in_bus.last_of_string = 1'b0;
        in_bus.out_capacity = 16'd0;
        in_bus.source_length = 16'd0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = 8'd0;
        cfg_bus.data = 8'd0;
        out_bus.ready = 1'b0;
        cfg_part = PART_FORM;
        cfg_ast = 1'b0;
        cfg_plus = 1'b0;
        cfg_pct = 1'b0;
        str_pos = 16'd0;
        str_cap = 16'd0;
        str_over = 1'b0;
        src_idle_pct = 24;
        snk_idle_pct = 70;
        mismatch_count = 0;
        cycle_count = 0;
        items_sent = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_after_reset();
        test_special_cases();
        test_config_regs();
        test_random_traffic(24, 70);
        test_random_traffic(70, 24);
        test_random_traffic(0, 0);
        wait_idle();

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
